// File: rtl/asru_pkg.sv
package asru_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int JOB_DEPTH      = 4;
  localparam int OUT_DEPTH      = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int IDX_W          = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_POINTS    = 3'd0,
    REG_TIME_STEP      = 3'd1,
    REG_SPACE_STEP     = 3'd2,
    REG_DIFFUSION_COEF = 3'd3,
    REG_ADVECTION_COEF = 3'd4,
    REG_UPWIND_COEF    = 3'd5,
    REG_X_ORIGIN       = 3'd6,
    REG_T_ORIGIN       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [12:0]        grid_points;
    logic [30:0]        time_step;
    logic [30:0]        space_step;
    logic [30:0]        diffusion_coef;
    logic [30:0]        advection_coef;
    logic [30:0]        upwind_coef;
    logic signed [31:0] x_origin;
    logic signed [31:0] t_origin;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_BOUNDARY = 2'd0,
    JOB_INTERIOR = 2'd1,
    JOB_LAST     = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic signed [31:0] u;
    logic signed [31:0] prev;
    logic signed [31:0] next;
    logic signed [31:0] xoff;
    logic signed [31:0] et;
    logic [IDX_W-1:0]   idx;
  } job_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [IDX_W-1:0]   point_index;
    logic               row_end;
  } res_t;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == {5{v[31]}}) r = v[31:0];
    else if (v[35]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

  // floor of product over 2^16, saturated
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [31:0] r;
    if (p[63:47] == {17{p[47]}}) r = p[47:16];
    else if (p[63]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

endpackage

// File: rtl/asru_fifo.sv
module asru_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

endmodule

// File: rtl/asru_front.sv
module asru_front #(
  parameter int MAX_POINTS = asru_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  asru_pkg::cfg_t     cfg,
  input  logic               accept,
  input  logic signed [31:0] sample,
  output logic               job_push,
  output asru_pkg::job_t     job
);

  localparam int CW = $clog2(MAX_POINTS);
  localparam int KW = (CW + 1 > 13) ? CW + 1 : 13;

  logic [CW-1:0]      col_r;
  logic signed [31:0] older_r, newer_r, xoff_r, et_r;
  logic [KW-1:0]      n_raw, n_lim, last_w, k_w;
  logic               at_first, at_last;
  logic signed [31:0] xoff_inc, et_inc;

  assign n_raw = KW'(cfg.grid_points);

  always_comb begin
    if (n_raw < KW'(3)) n_lim = KW'(3);
    else if (n_raw > KW'(MAX_POINTS)) n_lim = KW'(MAX_POINTS);
    else n_lim = n_raw;
  end

  assign last_w   = n_lim - KW'(1);
  assign k_w      = KW'(col_r);
  assign at_first = (col_r == '0);
  assign at_last  = (k_w >= last_w);
  assign xoff_inc = asru_pkg::sat36(36'(xoff_r) + 36'(signed'({1'b0, cfg.space_step})));
  assign et_inc   = asru_pkg::sat36(36'(et_r) + 36'(signed'({1'b0, cfg.time_step})));

  // second sample of a row gives no word
  assign job_push = accept && (col_r != CW'(1));

  always_comb begin
    job      = '0;
    job.u    = newer_r;
    job.prev = older_r;
    job.next = sample;
    job.xoff = xoff_r;
    job.et   = et_r;
    if (at_first) begin
      job.kind = asru_pkg::JOB_BOUNDARY;
      job.idx  = '0;
    end else begin
      job.kind = at_last ? asru_pkg::JOB_LAST : asru_pkg::JOB_INTERIOR;
      job.idx  = asru_pkg::IDX_W'(col_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      older_r <= '0;
      newer_r <= '0;
      xoff_r  <= '0;
      et_r    <= '0;
    end else if (accept) begin
      older_r <= newer_r;
      newer_r <= sample;
      if (at_first) begin
        col_r  <= CW'(1);
        xoff_r <= '0;
      end else if (at_last) begin
        col_r  <= '0;
        xoff_r <= '0;
        et_r   <= et_inc;
      end else begin
        col_r  <= col_r + CW'(1);
        xoff_r <= xoff_inc;
      end
    end
  end

endmodule

// File: rtl/asru_back.sv
module asru_back (
  input  logic           clk,
  input  logic           rst_n,
  input  asru_pkg::cfg_t cfg,
  input  logic           job_valid,
  input  asru_pkg::job_t job,
  output logic           job_pop,
  input  logic           res_ready,
  output logic           res_push,
  output asru_pkg::res_t res
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_PREP = 6'b000010,
    B_MUL  = 6'b000100,
    B_SAT  = 6'b001000,
    B_SUM  = 6'b010000,
    B_ADV  = 6'b100000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  asru_pkg::job_kind_t  kind_r;
  logic                 phase_r;
  logic [1:0]           mop_r;
  logic signed [31:0]   u_r, prev_r, next_r, xo_r, et_r;
  logic [asru_pkg::IDX_W-1:0] idx_r;
  logic signed [31:0]   t_r, x_r, base_r, lap_r, d3_r;
  logic [30:0]          c3_r;
  logic signed [63:0]   p_r;
  logic signed [31:0]   q0_r, src_r, dm_r, am_r;
  logic signed [31:0]   opa, opb, q;
  logic signed [63:0]   prod;
  logic signed [31:0]   ts_s;

  assign ts_s = signed'({1'b0, cfg.time_step});

  always_comb begin
    case (mop_r)
      2'd0: begin
        opa = x_r;
        opb = t_r;
      end
      2'd1: begin
        opa = ts_s;
        opb = q0_r;
      end
      2'd2: begin
        opa = signed'({1'b0, cfg.diffusion_coef});
        opb = lap_r;
      end
      default: begin
        opa = signed'({1'b0, c3_r});
        opb = d3_r;
      end
    endcase
  end

  assign prod = opa * opb;
  assign q    = asru_pkg::qsat(p_r);

  assign job_pop  = (state_r == B_IDLE) && job_valid;
  assign res_push = (state_r == B_SUM) && res_ready;

  always_comb begin
    res         = '0;
    res.row_end = phase_r;
    if (kind_r == asru_pkg::JOB_BOUNDARY) begin
      res.new_value   = asru_pkg::sat36(36'(t_r) + 36'(ts_s));
      res.point_index = idx_r;
    end else begin
      res.new_value   = asru_pkg::sat36(36'(base_r) + 36'(src_r) + 36'(dm_r) - 36'(am_r));
      res.point_index = phase_r ? idx_r + asru_pkg::IDX_W'(1) : idx_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (job_valid) state_nxt = B_PREP;
      B_PREP: state_nxt = (kind_r == asru_pkg::JOB_BOUNDARY) ? B_SUM : B_MUL;
      B_MUL:  state_nxt = B_SAT;
      B_SAT:  state_nxt = (mop_r == 2'd3) ? B_SUM : B_MUL;
      B_SUM: begin
        if (res_ready) begin
          state_nxt = (kind_r == asru_pkg::JOB_LAST && !phase_r) ? B_ADV : B_IDLE;
        end
      end
      B_ADV:  state_nxt = B_PREP;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      phase_r <= 1'b0;
      mop_r   <= '0;
      kind_r  <= asru_pkg::JOB_BOUNDARY;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            kind_r  <= job.kind;
            phase_r <= 1'b0;
          end
        end
        B_PREP:  mop_r <= '0;
        B_SAT:   mop_r <= mop_r + 2'd1;
        B_SUM: begin
          if (res_ready && kind_r == asru_pkg::JOB_LAST && !phase_r) phase_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        u_r    <= job.u;
        prev_r <= job.prev;
        next_r <= job.next;
        xo_r   <= job.xoff;
        et_r   <= job.et;
        idx_r  <= job.idx;
      end
      B_PREP: begin
        t_r <= asru_pkg::sat36(36'(cfg.t_origin) + 36'(et_r));
        x_r <= asru_pkg::sat36(36'(cfg.x_origin) + 36'(xo_r));
        if (!phase_r) begin
          base_r <= u_r;
          lap_r  <= asru_pkg::sat36(36'(next_r) - (36'(u_r) <<< 1) + 36'(prev_r));
          d3_r   <= asru_pkg::sat36(36'(next_r) - 36'(prev_r));
          c3_r   <= cfg.advection_coef;
        end else begin
          // upwind at the row end
          base_r <= next_r;
          lap_r  <= '0;
          d3_r   <= asru_pkg::sat36(36'(next_r) - 36'(u_r));
          c3_r   <= cfg.upwind_coef;
        end
      end
      B_MUL: p_r <= prod;
      B_SAT: begin
        case (mop_r)
          2'd0:    q0_r  <= q;
          2'd1:    src_r <= q;
          2'd2:    dm_r  <= q;
          default: am_r  <= q;
        endcase
      end
      B_ADV: xo_r <= asru_pkg::sat36(36'(xo_r) + 36'(signed'({1'b0, cfg.space_step})));
      default: ;
    endcase
  end

endmodule

// File: rtl/advection_stencil_row_update.sv
// sequencing: point 0 passes the prep and sum states; an interior point passes prep, one
//   multiply and saturate pass per product, and sum; a row end gives two words, the second after an advance state
// the back-end sequencer runs every product through one shared 32x32 multiplier and waits in sum
//   while the result queue is full; new samples wait in the job queue meanwhile; the second sample of a row is free
// reset: synchronous active-low rst_n empties both queues, clears window, column and time,
//   and loads the registers with their reset values
module advection_stencil_row_update #(
  parameter int MAX_POINTS = asru_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [asru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asru_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_push,
  input  logic signed [31:0]                  in_sample,
  output logic                                full,
  output logic signed [31:0]                  out_new_value,
  output logic [asru_pkg::IDX_W-1:0]          out_point_index,
  output logic                                out_row_end,
  output logic                                empty,
  input  logic                                pop
);

  localparam int JOB_W = $bits(asru_pkg::job_t);
  localparam int RES_W = $bits(asru_pkg::res_t);

  asru_pkg::cfg_t cfg_r;
  asru_pkg::job_t front_job, back_job;
  asru_pkg::res_t back_res, head_res;
  logic           accept, job_push, job_pop, job_empty;
  logic           res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_points    <= 13'd101;
      cfg_r.time_step      <= 31'd655;
      cfg_r.space_step     <= 31'd655;
      cfg_r.diffusion_coef <= 31'd32768;
      cfg_r.advection_coef <= 31'd32768;
      cfg_r.upwind_coef    <= 31'd65536;
      cfg_r.x_origin       <= '0;
      cfg_r.t_origin       <= '0;
    end else if (cfg_we) begin
      case (asru_pkg::reg_idx_t'(cfg_index))
        asru_pkg::REG_GRID_POINTS:    cfg_r.grid_points    <= cfg_data[12:0];
        asru_pkg::REG_TIME_STEP:      cfg_r.time_step      <= cfg_data[30:0];
        asru_pkg::REG_SPACE_STEP:     cfg_r.space_step     <= cfg_data[30:0];
        asru_pkg::REG_DIFFUSION_COEF: cfg_r.diffusion_coef <= cfg_data[30:0];
        asru_pkg::REG_ADVECTION_COEF: cfg_r.advection_coef <= cfg_data[30:0];
        asru_pkg::REG_UPWIND_COEF:    cfg_r.upwind_coef    <= cfg_data[30:0];
        asru_pkg::REG_X_ORIGIN:       cfg_r.x_origin       <= signed'(cfg_data);
        asru_pkg::REG_T_ORIGIN:       cfg_r.t_origin       <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  assign accept = in_push && !full;

  asru_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .sample   (in_sample),
    .job_push (job_push),
    .job      (front_job)
  );

  asru_fifo #(.W(JOB_W), .DEPTH(asru_pkg::JOB_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (front_job),
    .full  (full),
    .pop   (job_pop),
    .dout  (back_job),
    .empty (job_empty)
  );

  asru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (!job_empty),
    .job       (back_job),
    .job_pop   (job_pop),
    .res_ready (!res_full),
    .res_push  (res_push),
    .res       (back_res)
  );

  asru_fifo #(.W(RES_W), .DEPTH(asru_pkg::OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (head_res),
    .empty (empty)
  );

  assign out_new_value   = head_res.new_value;
  assign out_point_index = head_res.point_index;
  assign out_row_end     = head_res.row_end;

endmodule

// File: rtl/asru_checker.sv
module asru_checker #(
  parameter int MAX_POINTS = asru_pkg::MAX_POINTS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       full,
  input logic signed [31:0]         out_new_value,
  input logic [asru_pkg::IDX_W-1:0] out_point_index,
  input logic                       out_row_end,
  input logic                       empty,
  input logic                       pop
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_new_value) && $stable(out_point_index)
                       && $stable(out_row_end))
    else $error("stalled result word changed");

  // a row never ends at point 0 or 1
  a_row_end_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (MAX_POINTS <= 4096) && !empty && out_row_end |->
      out_point_index != 12'd0 && out_point_index != 12'd1)
    else $error("row end at too small a point");

  // the word after a row end opens the next row
  a_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && out_row_end ##1 !empty |-> out_point_index == 12'd0 && !out_row_end)
    else $error("row did not restart at point 0");

  // point 1 follows point 0
  a_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && out_point_index == 12'd0 && !out_row_end ##1 !empty |->
      out_point_index == 12'd1)
    else $error("point 1 did not follow point 0");

endmodule

bind advection_stencil_row_update asru_checker #(.MAX_POINTS(MAX_POINTS)) u_asru_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .out_new_value   (out_new_value),
  .out_point_index (out_point_index),
  .out_row_end     (out_row_end),
  .empty           (empty),
  .pop             (pop)
);
